[design/mbwr_pkg.sv]
// Package for the write-single-register RTU framer: request and byte types,
// protocol constants and the CRC-16 byte update. Depends on nothing.
package mbwr_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned IdxW       = $clog2(FrameBytes);

  localparam logic [7:0]  FuncWriteSingle = 8'h06;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  // Positions of the bytes within the frame, in transmit order.
  localparam logic [IdxW-1:0] IdxSlave   = IdxW'(0);
  localparam logic [IdxW-1:0] IdxFunc    = IdxW'(1);
  localparam logic [IdxW-1:0] IdxRegHi   = IdxW'(2);
  localparam logic [IdxW-1:0] IdxRegLo   = IdxW'(3);
  localparam logic [IdxW-1:0] IdxValHi   = IdxW'(4);
  localparam logic [IdxW-1:0] IdxValLo   = IdxW'(5);
  localparam logic [IdxW-1:0] IdxCrcLo   = IdxW'(6);
  localparam logic [IdxW-1:0] IdxCrcHi   = IdxW'(7);

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] register_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rsp_t;

  // Reflected CRC-16 over one byte, least significant bit first.
  function automatic logic [15:0] crc_update(logic [15:0] acc, logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/mbwr_frame_seq.sv]
// Frame sequencer: holds one request, steps through the eight frame bytes
// and folds each body byte into the running CRC. Depends on mbwr_pkg.
module mbwr_frame_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  mbwr_pkg::req_t req_i,
  output logic           req_stall_o,
  input  logic           advance_i,
  output logic           beat_valid_o,
  output mbwr_pkg::rsp_t beat_o
);

  logic                          busy_q, busy_d;
  logic [mbwr_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [15:0]                   crc_q, crc_d;
  mbwr_pkg::req_t                req_q;
  logic [7:0]                    cur_byte;
  logic                          is_last;
  logic                          take;
  logic                          load;

  always_comb begin
    unique case (idx_q)
      mbwr_pkg::IdxSlave: cur_byte = req_q.slave_address;
      mbwr_pkg::IdxFunc:  cur_byte = mbwr_pkg::FuncWriteSingle;
      mbwr_pkg::IdxRegHi: cur_byte = req_q.register_address[15:8];
      mbwr_pkg::IdxRegLo: cur_byte = req_q.register_address[7:0];
      mbwr_pkg::IdxValHi: cur_byte = req_q.register_value[15:8];
      mbwr_pkg::IdxValLo: cur_byte = req_q.register_value[7:0];
      mbwr_pkg::IdxCrcLo: cur_byte = crc_q[7:0];
      default:            cur_byte = crc_q[15:8];
    endcase
  end

  assign is_last      = (idx_q == mbwr_pkg::IdxCrcHi);
  assign take         = busy_q && advance_i;
  // A new request may enter while the final byte of the current one leaves.
  assign req_stall_o  = busy_q && !(take && is_last);
  assign load         = req_valid_i && !req_stall_o;

  assign beat_valid_o      = busy_q;
  assign beat_o.frame_byte = cur_byte;
  assign beat_o.last_byte  = is_last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = mbwr_pkg::IdxSlave;
      crc_d  = mbwr_pkg::CrcInit;
    end else if (take) begin
      idx_d = idx_q + 1'b1;
      if (idx_q < mbwr_pkg::IdxCrcLo) begin
        crc_d = mbwr_pkg::crc_update(crc_q, cur_byte);
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      req_q <= req_i;
    end
  end

endmodule

[design/mbwr_out_reg.sv]
// Output register: holds one frame beat towards the receiver and tells the
// sequencer when it can move on. Depends on mbwr_pkg.
module mbwr_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           beat_valid_i,
  input  mbwr_pkg::rsp_t beat_i,
  output logic           advance_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbwr_pkg::rsp_t out_data_o
);

  logic           valid_q;
  mbwr_pkg::rsp_t data_q;

  // The register refills when empty or when its beat is taken this cycle.
  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= beat_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && beat_valid_i) begin
      data_q <= beat_i;
    end
  end

endmodule

[design/modbus_write_register_framer.sv]
// Write-single-register RTU framer: each request beat becomes eight frame
// beats, the last one flagged. The first frame beat is held in the sequencer
// registers and then in the output register. Throughput: one frame beat per
// cycle while out_stall_i is low; the next request may enter as the last beat leaves.
// Reset clears only control state; nothing is kept between requests.
// Depends on mbwr_pkg, mbwr_frame_seq and mbwr_out_reg.
module modbus_write_register_framer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbwr_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbwr_pkg::rsp_t out_data_o
);

  logic           beat_valid;
  mbwr_pkg::rsp_t beat;
  logic           advance;

  mbwr_frame_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_i        (in_data_i),
    .req_stall_o  (in_stall_o),
    .advance_i    (advance),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  mbwr_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
